// File: hw/rtl/harc_pkg.sv
// shared widths, constants, register indexes and control types for the
// hold-and-average rate converter; no dependencies
`default_nettype none

package harc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 18;
  localparam int CNT_W    = 18;
  localparam int PHASE_W  = 19;
  localparam int DUE_W    = 20;
  localparam int SUM_W    = 36;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_RUN  = 64;
  localparam int RUN_W    = $clog2(MAX_RUN + 1);
  localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MAX_RUN - 1);
  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(MAX_RUN);

  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd48000;
  localparam logic [RATE_W-1:0] TARGET_RATE_RST = 18'd8000;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 2'd2;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic avg_start;
    logic avg_emit;
    logic hold_emit;
    logic mod_start;
    logic phase_from_due;
    logic phase_from_rem;
  } cmd_t;

  typedef struct packed {
    logic hold_mode;
    logic due_ge_src;
    logic frames_full;
    logic run_full;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/harc_div.sv
// two-lane iterative restoring divider, one quotient bit per cycle, shared
// 18-bit divisor; signed dividends, uses harc_pkg
`default_nettype none

module harc_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [harc_pkg::SUM_W-1:0] dividend_a,
  input  wire logic signed [harc_pkg::SUM_W-1:0] dividend_b,
  input  wire logic        [harc_pkg::CNT_W-1:0] divisor,
  output logic                                  busy,
  output logic signed      [harc_pkg::SUM_W-1:0] quot_a,
  output logic signed      [harc_pkg::SUM_W-1:0] quot_b,
  output logic             [harc_pkg::CNT_W-1:0] rem_a
);

  function automatic logic [harc_pkg::CNT_W:0] div_step(
    input logic [harc_pkg::CNT_W-1:0] rem,
    input logic                       din,
    input logic [harc_pkg::CNT_W-1:0] d
  );
    logic [harc_pkg::CNT_W:0] trial;
    logic [harc_pkg::CNT_W:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {diff[harc_pkg::CNT_W-1:0], 1'b1};
    end else begin
      div_step = {trial[harc_pkg::CNT_W-1:0], 1'b0};
    end
  endfunction

  logic                                busy_r;
  logic [harc_pkg::DIV_CNT_W-1:0]      step_r;
  logic [harc_pkg::CNT_W-1:0]          div_r;
  logic                                neg_a_r;
  logic                                neg_b_r;
  logic [harc_pkg::SUM_W-1:0]          qa_r;
  logic [harc_pkg::SUM_W-1:0]          qb_r;
  logic [harc_pkg::CNT_W-1:0]          ra_r;
  logic [harc_pkg::CNT_W-1:0]          rb_r;
  logic [harc_pkg::CNT_W:0]            sa_nxt;
  logic [harc_pkg::CNT_W:0]            sb_nxt;
  logic [harc_pkg::SUM_W-1:0]          mag_a;
  logic [harc_pkg::SUM_W-1:0]          mag_b;

  assign mag_a  = dividend_a[harc_pkg::SUM_W-1] ? -dividend_a : dividend_a;
  assign mag_b  = dividend_b[harc_pkg::SUM_W-1] ? -dividend_b : dividend_b;
  assign sa_nxt = div_step(ra_r, qa_r[harc_pkg::SUM_W-1], div_r);
  assign sb_nxt = div_step(rb_r, qb_r[harc_pkg::SUM_W-1], div_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == harc_pkg::DIV_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r   <= divisor;
      neg_a_r <= dividend_a[harc_pkg::SUM_W-1];
      neg_b_r <= dividend_b[harc_pkg::SUM_W-1];
      qa_r    <= mag_a;
      qb_r    <= mag_b;
      ra_r    <= '0;
      rb_r    <= '0;
    end else if (busy_r) begin
      qa_r <= {qa_r[harc_pkg::SUM_W-2:0], sa_nxt[0]};
      qb_r <= {qb_r[harc_pkg::SUM_W-2:0], sb_nxt[0]};
      ra_r <= sa_nxt[harc_pkg::CNT_W:1];
      rb_r <= sb_nxt[harc_pkg::CNT_W:1];
    end
  end

  assign busy   = busy_r;
  assign quot_a = neg_a_r ? -$signed(qa_r) : $signed(qa_r);
  assign quot_b = neg_b_r ? -$signed(qb_r) : $signed(qb_r);
  assign rem_a  = ra_r;

endmodule

`default_nettype wire

// File: hw/rtl/harc_datapath.sv
// datapath: config registers, phase accumulator, channel sums, frame count,
// divider and output register; uses harc_pkg and harc_div
`default_nettype none

module harc_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire harc_pkg::cmd_t                       cmd,
  output harc_pkg::sts_t                            sts,
  input  wire logic                                 cfg_valid,
  input  wire logic [harc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [harc_pkg::RATE_W-1:0]          cfg_data,
  input  wire logic signed [harc_pkg::SAMPLE_W-1:0] in_sample_left,
  input  wire logic signed [harc_pkg::SAMPLE_W-1:0] in_sample_right,
  input  wire logic                                 in_end_of_read,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [harc_pkg::SAMPLE_W-1:0]      out_left,
  output logic signed [harc_pkg::SAMPLE_W-1:0]      out_right,
  output logic                                      out_last_of_run,
  output logic                                      out_read_end,
  output logic                                      out_run_capped
);

  logic [harc_pkg::RATE_W-1:0]          source_rate_r;
  logic [harc_pkg::RATE_W-1:0]          target_rate_r;
  logic                                 stereo_r;
  logic [harc_pkg::PHASE_W-1:0]         phase_due_r;
  logic signed [harc_pkg::SUM_W-1:0]    sum_left_r;
  logic signed [harc_pkg::SUM_W-1:0]    sum_right_r;
  logic [harc_pkg::CNT_W-1:0]           frames_r;
  logic [harc_pkg::DUE_W-1:0]           due_r;
  logic signed [harc_pkg::SAMPLE_W-1:0] samp_l_r;
  logic signed [harc_pkg::SAMPLE_W-1:0] samp_r_r;
  logic                                 rend_r;
  logic [harc_pkg::RUN_W-1:0]           run_cnt_r;
  logic                                 out_valid_r;

  logic [harc_pkg::RATE_W-1:0]          src;
  logic [harc_pkg::DUE_W-1:0]           src_ext;
  logic [harc_pkg::DUE_W-1:0]           due_sub;
  logic                                 hold_last;
  logic                                 hold_capped;
  logic                                 div_start;
  logic signed [harc_pkg::SUM_W-1:0]    div_a;
  logic signed [harc_pkg::SUM_W-1:0]    div_b;
  logic [harc_pkg::CNT_W-1:0]           div_d;
  logic                                 div_busy;
  logic signed [harc_pkg::SUM_W-1:0]    quot_a;
  logic signed [harc_pkg::SUM_W-1:0]    quot_b;
  logic [harc_pkg::CNT_W-1:0]           rem_a;

  assign src     = (source_rate_r == '0) ? harc_pkg::RATE_W'(1) : source_rate_r;
  assign src_ext = {{(harc_pkg::DUE_W - harc_pkg::RATE_W){1'b0}}, src};
  assign due_sub = due_r - src_ext;
  assign hold_last   = (due_sub < src_ext) || (run_cnt_r == harc_pkg::RUN_LAST);
  assign hold_capped = (run_cnt_r == harc_pkg::RUN_LAST) && (due_sub >= src_ext);

  assign sts.hold_mode   = src < target_rate_r;
  assign sts.due_ge_src  = due_r >= src_ext;
  assign sts.frames_full = frames_r == harc_pkg::COUNT_MAX;
  assign sts.run_full    = run_cnt_r == harc_pkg::RUN_FULL;
  assign sts.div_busy    = div_busy;
  assign sts.out_free    = !out_valid_r || !out_stall;

  // modulo of the leftover phase shares lane a with the left average
  assign div_start = cmd.avg_start || cmd.mod_start;
  assign div_a = cmd.mod_start ?
                 $signed({{(harc_pkg::SUM_W - harc_pkg::DUE_W){1'b0}}, due_r}) : sum_left_r;
  assign div_b = sum_right_r;
  assign div_d = cmd.mod_start ? src : frames_r;

  harc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend_a (div_a),
    .dividend_b (div_b),
    .divisor    (div_d),
    .busy       (div_busy),
    .quot_a     (quot_a),
    .quot_b     (quot_b),
    .rem_a      (rem_a)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_rate_r <= harc_pkg::SOURCE_RATE_RST;
      target_rate_r <= harc_pkg::TARGET_RATE_RST;
      stereo_r      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        harc_pkg::CFG_SOURCE_RATE: source_rate_r <= cfg_data;
        harc_pkg::CFG_TARGET_RATE: target_rate_r <= cfg_data;
        harc_pkg::CFG_STEREO:      stereo_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_due_r <= '0;
      sum_left_r  <= '0;
      sum_right_r <= '0;
      frames_r    <= '0;
      run_cnt_r   <= '0;
    end else begin
      if (cmd.capture) begin
        run_cnt_r <= '0;
      end else if (cmd.hold_emit) begin
        run_cnt_r <= run_cnt_r + 1'b1;
      end
      if (cmd.accumulate) begin
        sum_left_r  <= sum_left_r +
                       {{(harc_pkg::SUM_W - harc_pkg::SAMPLE_W){samp_l_r[harc_pkg::SAMPLE_W-1]}},
                        samp_l_r};
        sum_right_r <= sum_right_r +
                       {{(harc_pkg::SUM_W - harc_pkg::SAMPLE_W){samp_r_r[harc_pkg::SAMPLE_W-1]}},
                        samp_r_r};
        frames_r    <= frames_r + 1'b1;
      end else if (cmd.avg_emit) begin
        sum_left_r  <= '0;
        sum_right_r <= '0;
        frames_r    <= '0;
      end
      if (cmd.phase_from_due) begin
        phase_due_r <= due_r[harc_pkg::PHASE_W-1:0];
      end else if (cmd.phase_from_rem) begin
        phase_due_r <= {{(harc_pkg::PHASE_W - harc_pkg::CNT_W){1'b0}}, rem_a};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp_l_r <= in_sample_left;
      samp_r_r <= stereo_r ? in_sample_right : '0;
      rend_r   <= in_end_of_read;
      due_r    <= {1'b0, phase_due_r} + {{(harc_pkg::DUE_W - harc_pkg::RATE_W){1'b0}},
                                         target_rate_r};
    end else if (cmd.hold_emit || (cmd.avg_start && sts.due_ge_src)) begin
      due_r <= due_sub;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.hold_emit || cmd.avg_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_emit) begin
      out_left        <= samp_l_r;
      out_right       <= samp_r_r;
      out_last_of_run <= hold_last;
      out_read_end    <= hold_last && rend_r;
      out_run_capped  <= hold_capped;
    end else if (cmd.avg_emit) begin
      out_left        <= quot_a[harc_pkg::SAMPLE_W-1:0];
      out_right       <= stereo_r ? quot_b[harc_pkg::SAMPLE_W-1:0] : '0;
      out_last_of_run <= 1'b1;
      out_read_end    <= rend_r;
      out_run_capped  <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hw/rtl/harc_ctrl.sv
// controller state machine: sequences capture, hold runs, averaging and
// phase write-back; uses harc_pkg command and status types
`default_nettype none

module harc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire harc_pkg::sts_t sts,
  output harc_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HOLD = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.hold_mode ? ST_HOLD : ST_ACC;
        end
      end
      ST_HOLD: begin
        if (!sts.due_ge_src) begin
          cmd.phase_from_due = 1'b1;
          state_nxt          = ST_IDLE;
        end else if (sts.run_full) begin
          cmd.mod_start = 1'b1;
          state_nxt     = ST_MOD;
        end else if (sts.out_free) begin
          cmd.hold_emit = 1'b1;
        end
      end
      ST_MOD: begin
        if (!sts.div_busy) begin
          cmd.phase_from_rem = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
        state_nxt      = ST_CHK;
      end
      ST_CHK: begin
        if (sts.due_ge_src || sts.frames_full) begin
          cmd.avg_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.phase_from_due = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy && sts.out_free) begin
          cmd.avg_emit       = 1'b1;
          cmd.phase_from_due = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != ST_IDLE;

endmodule

`default_nettype wire

// File: hw/rtl/hold_and_average_rate_converter_core.sv
// hold-and-average rate converter top level: controller plus datapath
// hold mode: one result per cycle while the output is not stalled, and the
//   item ends with a phase write-back after its last result; a capped run also
//   computes the phase remainder in the shared 36-step divider
// average mode: accumulate and check; an item with a result also waits for the 36-step divider
// reset: synchronous active-low, rates back to 48000/8000, mono, state cleared
`default_nettype none

module hold_and_average_rate_converter_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [harc_pkg::SAMPLE_W-1:0] in_sample_left,
  input  wire logic signed [harc_pkg::SAMPLE_W-1:0] in_sample_right,
  input  wire logic                                 in_end_of_read,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [harc_pkg::SAMPLE_W-1:0]      out_left,
  output logic signed [harc_pkg::SAMPLE_W-1:0]      out_right,
  output logic                                      out_last_of_run,
  output logic                                      out_read_end,
  output logic                                      out_run_capped,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [harc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [harc_pkg::RATE_W-1:0]          cfg_data
);

  harc_pkg::cmd_t cmd;
  harc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  harc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  harc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .in_end_of_read  (in_end_of_read),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_last_of_run (out_last_of_run),
    .out_read_end    (out_read_end),
    .out_run_capped  (out_run_capped)
  );

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  // flags only on the final result of a run
  a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_run || (!out_read_end && !out_run_capped)))
    else $error("read_end or run_capped on a result that is not last");

  // never overwrite a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hold_emit || cmd.avg_emit) |-> (!out_valid || !out_stall))
    else $error("result register loaded while stalled");

endmodule

`default_nettype wire

// File: tb/tb_hold_and_average_rate_converter_core.sv
`timescale 1ns / 100ps
// self-checking testbench for hold_and_average_rate_converter_core: directed and random
// frames under random idling, checked against an in-bench resampler; needs harc_pkg

module tb_hold_and_average_rate_converter_core;

  localparam int MAX_IDLE = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int SINK_HOLD_CYCLES = 500;
  localparam int RANDOM_FRAMES = 420;
  localparam logic [harc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [harc_pkg::RATE_W-1:0] RATE_TOP = '1;

  typedef struct packed {
    logic signed [harc_pkg::SAMPLE_W-1:0] left;
    logic signed [harc_pkg::SAMPLE_W-1:0] right;
    logic last_of_run;
    logic read_end;
    logic run_capped;
  } out_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [harc_pkg::SAMPLE_W-1:0] in_sample_left = '0;
  logic signed [harc_pkg::SAMPLE_W-1:0] in_sample_right = '0;
  logic in_end_of_read = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [harc_pkg::SAMPLE_W-1:0] out_left;
  logic signed [harc_pkg::SAMPLE_W-1:0] out_right;
  logic out_last_of_run;
  logic out_read_end;
  logic out_run_capped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [harc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [harc_pkg::RATE_W-1:0] cfg_data = '0;

  // resampler state mirrored from the block
  logic [harc_pkg::RATE_W-1:0] rate_in_hz = harc_pkg::SOURCE_RATE_RST;
  logic [harc_pkg::RATE_W-1:0] rate_out_hz = harc_pkg::TARGET_RATE_RST;
  logic stereo_mode = 1'b0;
  logic [harc_pkg::PHASE_W-1:0] phase_acc = '0;
  longint acc_left = 0;
  longint acc_right = 0;
  int acc_frames = 0;

  out_frame_t expected_frames[$];
  int fail_count = 0;
  bit frame_idling = 1'b1;
  bit sink_idling = 1'b1;
  bit sink_hold_req = 1'b0;

  hold_and_average_rate_converter_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .in_end_of_read  (in_end_of_read),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_last_of_run (out_last_of_run),
    .out_read_end    (out_read_end),
    .out_run_capped  (out_run_capped),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void resample_frame(
    input logic signed [harc_pkg::SAMPLE_W-1:0] left_in,
    input logic signed [harc_pkg::SAMPLE_W-1:0] right_in,
    input logic eor
  );
    logic signed [harc_pkg::SAMPLE_W-1:0] right;
    longint unsigned src;
    longint unsigned due;
    longint avg_left;
    longint avg_right;
    int runs;
    logic capped;
    out_frame_t frame;
    right = stereo_mode ? right_in : '0;
    src = (rate_in_hz == '0) ? 1 : rate_in_hz;
    due = phase_acc + rate_out_hz;
    runs = 0;
    capped = 1'b0;
    if (src < rate_out_hz) begin
      while (due >= src && runs < harc_pkg::MAX_RUN) begin
        runs++;
        due -= src;
      end
      if (due >= src) begin
        capped = 1'b1;
        due = due % src;
      end
      for (int k = 0; k < runs; k++) begin
        frame.left = left_in;
        frame.right = right;
        frame.last_of_run = (k == runs - 1);
        frame.read_end = frame.last_of_run & eor;
        frame.run_capped = frame.last_of_run & capped;
        expected_frames.push_back(frame);
      end
    end else begin
      acc_left += longint'(left_in);
      if (stereo_mode) acc_right += longint'(right);
      acc_frames++;
      if (due >= src || acc_frames >= harc_pkg::COUNT_MAX) begin
        avg_left = acc_left / longint'(acc_frames);
        avg_right = stereo_mode ? acc_right / longint'(acc_frames) : 0;
        frame.left = 16'(avg_left);
        frame.right = 16'(avg_right);
        frame.last_of_run = 1'b1;
        frame.read_end = eor;
        frame.run_capped = 1'b0;
        expected_frames.push_back(frame);
        acc_left = 0;
        acc_right = 0;
        acc_frames = 0;
        if (due >= src) due -= src;
      end
    end
    phase_acc = harc_pkg::PHASE_W'(due);
  endfunction

  function automatic void check_field(input string field, input logic signed [31:0] exp_val,
                                      input logic signed [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s expected %0d actual %0d", field, exp_val, act_val);
      fail_count++;
    end
  endfunction

  function automatic logic signed [harc_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom());
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    out_frame_t exp_frame;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("result with no item pending: left %0d right %0d", out_left, out_right);
        fail_count++;
      end else begin
        exp_frame = expected_frames.pop_front();
        check_field("out_left", exp_frame.left, out_left);
        check_field("out_right", exp_frame.right, out_right);
        check_field("out_last_of_run", exp_frame.last_of_run, out_last_of_run);
        check_field("out_read_end", exp_frame.read_end, out_read_end);
        check_field("out_run_capped", exp_frame.run_capped, out_run_capped);
      end
    end
  end

  // result sink with random stalls and an on-demand long hold
  initial begin : result_sink
    int sink_wait;
    wait (rst_n);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end
      sink_wait = sink_idling ? $urandom_range(0, MAX_IDLE) : 0;
      if (sink_wait > 0) begin
        out_stall <= 1'b1;
        repeat (sink_wait) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && !sink_hold_req);
    end
  end

  task automatic send_frame(input logic signed [harc_pkg::SAMPLE_W-1:0] left_in,
                            input logic signed [harc_pkg::SAMPLE_W-1:0] right_in,
                            input logic eor);
    int gap;
    gap = frame_idling ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_left <= left_in;
    in_sample_right <= right_in;
    in_end_of_read <= eor;
    do @(posedge clk); while (in_stall);
    resample_frame(left_in, right_in, eor);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rates(input logic [harc_pkg::RATE_W-1:0] src,
                           input logic [harc_pkg::RATE_W-1:0] tgt,
                           input logic st);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= harc_pkg::CFG_SOURCE_RATE;
    cfg_data <= src;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= harc_pkg::CFG_TARGET_RATE;
    cfg_data <= tgt;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= harc_pkg::CFG_STEREO;
    cfg_data <= {17'($urandom()), st};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_UNUSED;
    cfg_data <= 18'($urandom());
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate_in_hz = src;
    rate_out_hz = tgt;
    stereo_mode = st;
  endtask

  // reset rates, mono: right channel ignored, end marks lost on frames with no result
  task automatic test_reset_defaults();
    send_frame(16'sh7fff, 16'sh7fff, 1'b0);
    send_frame(-16'sh8000, 16'sh1234, 1'b0);
    send_frame(16'sh0000, -16'sh8000, 1'b1);
    send_frame(-16'sh0001, 16'sh7fff, 1'b0);
    send_frame(16'sh0001, 16'sh0000, 1'b0);
    send_frame(16'sh7fff, -16'sh0001, 1'b1);
  endtask

  task automatic test_hold_stereo();
    set_rates(18'd8000, 18'd48000, 1'b1);
    send_frame(16'sh7fff, -16'sh8000, 1'b1);
    send_frame(-16'sh8000, 16'sh7fff, 1'b0);
    set_rates(18'd44100, 18'd48000, 1'b0);
    send_frame(16'sh0123, 16'sh7fff, 1'b1);
    send_frame(-16'sh0123, 16'sh7fff, 1'b0);
  endtask

  // truncation toward zero on both channels
  task automatic test_average_stereo();
    set_rates(18'd48000, 18'd16000, 1'b1);
    send_frame(-16'sh8000, 16'sh0001, 1'b0);
    send_frame(-16'sh8000, 16'sh0001, 1'b0);
    send_frame(16'sh7fff, -16'sh0001, 1'b1);
    send_frame(-16'sh0001, 16'sh7fff, 1'b0);
    send_frame(-16'sh0001, 16'sh7fff, 1'b1);
    send_frame(16'sh0000, 16'sh7ffe, 1'b0);
  endtask

  task automatic test_equal_rates();
    set_rates(18'd44100, 18'd44100, 1'b1);
    send_frame(16'sh7fff, -16'sh8000, 1'b1);
    send_frame(-16'sh8000, 16'sh7fff, 1'b0);
    send_frame(16'sh5555, -16'sh2aab, 1'b1);
  endtask

  task automatic test_capped_runs();
    set_rates(18'd1, 18'd192000, 1'b0);
    send_frame(16'sh7fff, 16'sh0000, 1'b1);
    set_rates(18'd0, RATE_TOP, 1'b1);
    send_frame(-16'sh8000, 16'sh7fff, 1'b1);
    set_rates(18'd1000, 18'd100000, 1'b0);
    send_frame(16'sh0f0f, 16'sh0000, 1'b0);
  endtask

  task automatic test_zero_source_rate();
    set_rates(18'd0, 18'd0, 1'b0);
    send_frame(16'sh1000, 16'sh0000, 1'b1);
    set_rates(18'd0, 18'd1, 1'b1);
    send_frame(-16'sh1000, 16'sh2000, 1'b1);
    send_frame(16'sh7fff, -16'sh8000, 1'b0);
  endtask

  // long output hold fills the block, then the sender waits for everything
  task automatic test_output_backpressure();
    set_rates(18'd8000, 18'd48000, 1'b1);
    frame_idling = 1'b0;
    sink_hold_req = 1'b1;
    repeat (40) send_frame(rand_sample(), rand_sample(), 1'($urandom()));
    settle();
    frame_idling = 1'b1;
    repeat (20) send_frame(rand_sample(), rand_sample(), 1'($urandom()));
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    int src;
    int tgt;
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      case ($urandom_range(0, 5))
        0: begin
          src = $urandom_range(1, 48000);
          tgt = src * $urandom_range(2, 6);
          if (tgt > int'(RATE_TOP)) tgt = int'(RATE_TOP);
        end
        1: begin
          tgt = $urandom_range(1, 48000);
          src = tgt * $urandom_range(1, 8);
          if (src > int'(RATE_TOP)) src = int'(RATE_TOP);
        end
        2: begin
          src = $urandom_range(0, 40);
          tgt = $urandom_range(3000, int'(RATE_TOP));
        end
        3: begin
          src = $urandom_range(1, int'(RATE_TOP));
          tgt = src;
        end
        4: begin
          src = $urandom_range(0, int'(RATE_TOP));
          tgt = $urandom_range(0, int'(RATE_TOP));
        end
        default: begin
          case ($urandom_range(0, 3))
            0: src = 0;
            1: src = 1;
            2: src = 192000;
            default: src = int'(RATE_TOP);
          endcase
          case ($urandom_range(0, 3))
            0: tgt = 0;
            1: tgt = 1;
            2: tgt = 192000;
            default: tgt = int'(RATE_TOP);
          endcase
        end
      endcase
      set_rates(harc_pkg::RATE_W'(src), harc_pkg::RATE_W'(tgt), 1'($urandom()));
      frame_idling = ($urandom_range(0, 3) != 0);
      sink_idling = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(10, 50);
      repeat (burst) send_frame(rand_sample(), rand_sample(), 1'($urandom()));
      sent += burst;
    end
    frame_idling = 1'b1;
    sink_idling = 1'b1;
  endtask

  initial begin : test_sequence
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_hold_stereo();
    test_average_stereo();
    test_equal_rates();
    test_capped_runs();
    test_zero_source_rate();
    test_output_backpressure();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("PASS hold_and_average_rate_converter_core");
    end else begin
      $display("FAIL hold_and_average_rate_converter_core");
    end
    $finish;
  end

  initial begin : run_limit
    #50_000_000;
    $display("FAIL hold_and_average_rate_converter_core");
    $finish;
  end

endmodule
